// ----- src/rsch_pkg.sv -----
// ---------------------------------------------------------------------------
// rsch_pkg
// Types and constants shared by the ray/sphere closest-hit block.
// ---------------------------------------------------------------------------
package rsch_pkg;

   localparam int NUM_SPHERES = 16;
   localparam int SLOT_W      = (NUM_SPHERES > 1) ? $clog2(NUM_SPHERES) : 1;
   localparam int CNT_W       = $clog2(NUM_SPHERES + 1);
   localparam int SQRT_BITS   = 38;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_TRACE = 1'b1;

   localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic               action;
      logic [3:0]         slot;
      logic [30:0]        radius;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [30:0] hit_distance;
      logic [3:0]  hit_index;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_PROD,
      ST_SUM,
      ST_DOT,
      ST_SQB,
      ST_RAD,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

// ----- src/rsch_if.sv -----
// ---------------------------------------------------------------------------
// rsch_if
// Valid/ready channel carrying one payload word.
// ---------------------------------------------------------------------------
interface rsch_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- src/rsch_sqrt.sv -----
// ---------------------------------------------------------------------------
// rsch_sqrt
// Bit-serial integer square root by shift and subtract, one result bit per
// cycle; done pulses for one cycle once the root is final.
// ---------------------------------------------------------------------------
module rsch_sqrt import rsch_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [75:0] value,
   output logic        done,
   output logic [37:0] root
);
   logic [75:0] val_ff, val_in;
   logic [39:0] rem_ff, rem_in;
   logic [37:0] root_ff, root_in;
   logic [5:0]  bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [41:0] shifted;
   logic [41:0] trial;

   always_comb begin
      // bring down the next two radicand bits and try root*4 + 1
      shifted = {rem_ff, val_ff[75:74]};
      trial   = {2'b00, root_ff, 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         bit_in  = 6'(SQRT_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[73:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = 40'(shifted - trial);
            root_in = {root_ff[36:0], 1'b1};
         end else begin
            rem_in  = 40'(shifted);
            root_in = {root_ff[36:0], 1'b0};
         end
         if (bit_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ----- src/ray_sphere_closest_hit_top.sv -----
// ---------------------------------------------------------------------------
// ray_sphere_closest_hit_top
// Closest-hit ray test against a table of spheres held in RAM.
// ---------------------------------------------------------------------------
// A load word is written as it is accepted, and the block stays ready.
// A trace word walks the table one slot at a time: an empty slot is skipped
// in the read state; a valid slot passes RAM read, difference, products, dot
// product, b squared and radicand, then the bit-serial square root (38 result
// bits and a done pulse), which is skipped when the radicand is negative.
// A new word is taken whenever the block is idle, even while the last result
// waits; a finished trace holds in its final state until the output register
// is free. Valid bits reset at once; no clearing pass.
module ray_sphere_closest_hit_top import rsch_pkg::*; (
   input logic     clock,
   input logic     reset,
   rsch_if.sink    req,
   rsch_if.source  rsp
);
   logic [126:0] mem [NUM_SPHERES];
   logic [126:0] rd_ff;
   logic [NUM_SPHERES-1:0] valid_ff;
   state_type st_ff, st_in;
   req_type   ray_ff;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic signed [39:0] best_ff, best_in;
   logic [SLOT_W-1:0] bidx_ff, bidx_in;
   logic rsp_v_ff, rsp_v_in;
   rsp_type rsp_ff, rsp_in;
   logic signed [32:0] op_ff [3];
   logic [32:0] opm [3];
   logic signed [49:0] pr_ff [3];
   logic [65:0] sq_ff [3];
   logic [75:0] sqs_ff;
   logic [61:0] rr_ff;
   logic signed [39:0] b_ff;
   logic [35:0] bb_hh_ff, bb_hl_ff, bb_ll_ff;
   logic [75:0] sqr_a, rad;
   logic neg_ff;
   logic sq_start, sq_done;
   logic [37:0] root;
   logic signed [51:0] dot;
   logic signed [39:0] b_next, t0, t1;
   logic [35:0] bmag;
   logic slot_ok, in_rdy, out_free;

   assign in_rdy  = (st_ff == ST_IDLE);
   assign req.ready = in_rdy;
   assign slot_ok = 32'(req.data.slot) < NUM_SPHERES;
   assign out_free = !rsp_v_ff || rsp.ready;
   assign sq_start = (st_ff == ST_RAD);

   always_ff @(posedge clock) begin
      if (req.valid && in_rdy && req.data.action == ACT_LOAD && slot_ok)
         mem[req.data.slot[SLOT_W-1:0]] <= {req.data.radius, req.data.point_x,
                                            req.data.point_y, req.data.point_z};
      rd_ff <= mem[idx_ff[SLOT_W-1:0]];
   end

   rsch_sqrt u_sqrt (.clock, .reset, .start(sq_start), .value(rad),
                     .done(sq_done), .root);

   always_comb begin
      for (int i = 0; i < 3; i++)
         opm[i] = op_ff[i][32] ? 33'(-op_ff[i]) : 33'(op_ff[i]);
      dot    = 52'(pr_ff[0]) + 52'(pr_ff[1]) + 52'(pr_ff[2]);
      b_next = 40'(dot >>> 14);
      bmag   = b_ff[39] ? 36'(-b_ff) : 36'(b_ff);
      // b squared from three 18-bit partial products, plus r squared
      sqr_a  = (76'(bb_hh_ff) << 36) + (76'(bb_hl_ff) << 19) + 76'(bb_ll_ff)
             + 76'(rr_ff);
      rad    = sqr_a - sqs_ff;
      t0     = b_ff - 40'(root);
      t1     = b_ff + 40'(root);
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (req.valid && in_rdy && req.data.action == ACT_TRACE)
                     st_in = ST_READ;
         ST_READ: begin
            if (idx_ff == CNT_W'(NUM_SPHERES)) st_in = ST_DONE;
            else if (valid_ff[idx_ff[SLOT_W-1:0]]) st_in = ST_PROD;
         end
         ST_PROD: st_in = ST_SUM;
         ST_SUM:  st_in = ST_DOT;
         ST_DOT:  st_in = ST_SQB;
         ST_SQB:  st_in = ST_RAD;
         ST_RAD:  st_in = ST_SQRT;
         ST_SQRT: begin
            if (neg_ff || sq_done) st_in = ST_READ;
         end
         ST_DONE: if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff; found_in = found_ff; best_in = best_ff; bidx_in = bidx_ff;
      rsp_v_in = rsp_v_ff; rsp_in = rsp_ff;
      if (rsp_v_ff && rsp.ready) rsp_v_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            idx_in = '0; found_in = 1'b0;
         end
         ST_READ: begin
            if (idx_ff != CNT_W'(NUM_SPHERES) && !valid_ff[idx_ff[SLOT_W-1:0]])
               idx_in = idx_ff + 1'b1;
         end
         ST_SQRT: begin
            if (neg_ff || sq_done) idx_in = idx_ff + 1'b1;
            if (!neg_ff && sq_done) begin
               if (t0 > 0 && (!found_ff || t0 < best_ff)) begin
                  found_in = 1'b1; best_in = t0; bidx_in = idx_ff[SLOT_W-1:0];
               end else if (t0 <= 0 && t1 > 0 && (!found_ff || t1 < best_ff)) begin
                  found_in = 1'b1; best_in = t1; bidx_in = idx_ff[SLOT_W-1:0];
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_v_in = 1'b1;
               rsp_in.hit = found_ff;
               rsp_in.hit_distance = !found_ff ? 31'd0 :
                  (best_ff > 40'sd2147483647) ? DIST_MAX : best_ff[30:0];
               rsp_in.hit_index = found_ff ? 4'(bidx_ff) : 4'd0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; valid_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rsp_v_ff <= rsp_v_in;
         if (req.valid && in_rdy && req.data.action == ACT_LOAD && slot_ok)
            valid_ff[req.data.slot[SLOT_W-1:0]] <= 1'b1;
      end
      idx_ff <= idx_in; found_ff <= found_in; best_ff <= best_in;
      bidx_ff <= bidx_in; rsp_ff <= rsp_in;
      if (req.valid && in_rdy) ray_ff <= req.data;
      if (st_ff == ST_PROD) begin
         op_ff[0] <= 33'(signed'(rd_ff[95:64])) - 33'(ray_ff.point_x);
         op_ff[1] <= 33'(signed'(rd_ff[63:32])) - 33'(ray_ff.point_y);
         op_ff[2] <= 33'(signed'(rd_ff[31:0]))  - 33'(ray_ff.point_z);
         rr_ff    <= 62'(rd_ff[126:96]) * 62'(rd_ff[126:96]);
      end
      if (st_ff == ST_SUM) begin
         pr_ff[0] <= 50'(op_ff[0]) * 50'(ray_ff.dir_x);
         pr_ff[1] <= 50'(op_ff[1]) * 50'(ray_ff.dir_y);
         pr_ff[2] <= 50'(op_ff[2]) * 50'(ray_ff.dir_z);
         for (int i = 0; i < 3; i++)
            sq_ff[i] <= 66'(opm[i]) * 66'(opm[i]);
      end
      if (st_ff == ST_DOT) begin
         b_ff   <= b_next;
         sqs_ff <= 76'(sq_ff[0]) + 76'(sq_ff[1]) + 76'(sq_ff[2]);
      end
      if (st_ff == ST_SQB) begin
         bb_hh_ff <= 36'(bmag[35:18]) * 36'(bmag[35:18]);
         bb_hl_ff <= 36'(bmag[35:18]) * 36'(bmag[17:0]);
         bb_ll_ff <= 36'(bmag[17:0]) * 36'(bmag[17:0]);
      end
      if (st_ff == ST_RAD) neg_ff <= sqr_a < sqs_ff;
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.data  = rsp_ff;
endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the ray/sphere closest-hit block: loads spheres,
// traces rays, and checks every result against a bit-exact predictor.
// ---------------------------------------------------------------------------
module tb;
   import rsch_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsch_if #(.payload_type(req_type)) req_ch ();
   rsch_if #(.payload_type(rsp_type)) rsp_ch ();

   ray_sphere_closest_hit_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // predictor state
   logic [30:0]        tbl_radius [NUM_SPHERES];
   logic signed [31:0] tbl_center [NUM_SPHERES][3];
   logic               tbl_valid  [NUM_SPHERES];

   rsp_type hit_queue [$];
   int      errors;
   int      n_loads, n_traces, n_hits;
   bit      rx_hold;
   int      rx_hold_cycles;

   function automatic logic [37:0] isqrt(logic [75:0] v);
      logic [37:0] root;
      logic [37:0] cand;
      root = '0;
      for (int k = SQRT_BITS - 1; k >= 0; k--) begin
         cand = root | (38'd1 << k);
         if ({38'd0, cand} * {38'd0, cand} <= v)
            root = cand;
      end
      return root;
   endfunction

   function automatic rsp_type closest_hit(req_type w);
      rsp_type r;
      logic signed [33:0] op [3];
      logic signed [63:0] dot;
      logic signed [63:0] b;
      logic signed [63:0] rt;
      logic signed [63:0] t;
      logic signed [63:0] best;
      logic signed [15:0] dv [3];
      logic signed [31:0] ov [3];
      logic [79:0] sq;
      logic [79:0] a;
      logic [63:0] bmag;
      bit found;
      bit ok;
      found = 0;
      best  = 0;
      r     = '0;
      ov[0] = w.point_x; ov[1] = w.point_y; ov[2] = w.point_z;
      dv[0] = w.dir_x;   dv[1] = w.dir_y;   dv[2] = w.dir_z;
      for (int s = 0; s < NUM_SPHERES; s++) begin
         if (!tbl_valid[s])
            continue;
         dot = 0;
         sq  = 0;
         for (int i = 0; i < 3; i++) begin
            op[i] = 34'(tbl_center[s][i]) - 34'(ov[i]);
            dot   = dot + 64'(op[i]) * 64'(dv[i]);
            sq    = sq + 80'(op[i]) * 80'(op[i]);
         end
         b    = dot >>> 14;   // floor toward minus infinity
         bmag = (b < 0) ? 64'(-b) : 64'(b);
         a    = 80'(bmag) * 80'(bmag) + 80'(tbl_radius[s]) * 80'(tbl_radius[s]);
         ok   = 0;
         if (a >= sq) begin
            rt = 64'(isqrt(76'(a - sq)));
            t  = b - rt;
            if (t > 0)
               ok = 1;
            else begin
               t = b + rt;
               ok = (t > 0);
            end
         end
         if (ok && (!found || t < best)) begin
            found = 1;
            best  = t;
            r.hit_index = 4'(s);
         end
      end
      if (found) begin
         r.hit = 1'b1;
         r.hit_distance = (best > 64'(DIST_MAX)) ? DIST_MAX : 31'(best);
      end
      return r;
   endfunction

   // Apply a word to the predictor once it is accepted.
   task automatic predict(req_type w);
      if (w.action == ACT_LOAD) begin
         tbl_radius[w.slot]    = w.radius;
         tbl_center[w.slot][0] = w.point_x;
         tbl_center[w.slot][1] = w.point_y;
         tbl_center[w.slot][2] = w.point_z;
         tbl_valid[w.slot]     = 1'b1;
         n_loads++;
      end else begin
         hit_queue.push_back(closest_hit(w));
         n_traces++;
      end
   endtask

   function automatic req_type load_word(int s, logic [30:0] r,
                                         logic signed [31:0] x, y, z);
      req_type w;
      w = '0;
      w.action = ACT_LOAD;
      w.slot = 4'(s);
      w.radius = r;
      w.point_x = x; w.point_y = y; w.point_z = z;
      w.dir_x = 16'($urandom);  // ignored on load
      w.dir_y = 16'($urandom);
      w.dir_z = 16'($urandom);
      return w;
   endfunction

   function automatic req_type trace_word(logic signed [31:0] x, y, z,
                                          logic signed [15:0] dx, dy, dz);
      req_type w;
      w = '0;
      w.action = ACT_TRACE;
      w.slot = 4'($urandom);
      w.radius = 31'($urandom);
      w.point_x = x; w.point_y = y; w.point_z = z;
      w.dir_x = dx; w.dir_y = dy; w.dir_z = dz;
      return w;
   endfunction

   function automatic logic signed [15:0] rand_dir();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 6))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom);
         default: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   function automatic logic [30:0] rand_radius();
      case ($urandom_range(0, 5))
         0: return 31'h7FFF_FFFF;
         1: return 31'd0;
         2: return 31'($urandom);
         default: return 31'($urandom_range(1, 1 << 18));
      endcase
   endfunction

   // Offer a word and hold it until accepted; valid stays up for the caller.
   task automatic send_word(req_type w);
      req_ch.valid <= 1'b1;
      req_ch.data  <= w;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      predict(w);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      while (hit_queue.size() != 0)
         @(negedge clock);
      repeat (800) @(negedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rx_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (rx_hold_cycles) @(negedge clock);
            rx_hold = 0;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Check every accepted result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (hit_queue.size() == 0) begin
            $error("unexpected result word %p", rsp_ch.data);
            errors++;
         end else begin
            exp_r = hit_queue.pop_front();
            if (exp_r.hit) n_hits++;
            if (rsp_ch.data.hit !== exp_r.hit) begin
               $error("hit: expected %0d actual %0d", exp_r.hit, rsp_ch.data.hit);
               errors++;
            end
            if (rsp_ch.data.hit_distance !== exp_r.hit_distance) begin
               $error("hit_distance: expected %0d actual %0d",
                      exp_r.hit_distance, rsp_ch.data.hit_distance);
               errors++;
            end
            if (rsp_ch.data.hit_index !== exp_r.hit_index) begin
               $error("hit_index: expected %0d actual %0d",
                      exp_r.hit_index, rsp_ch.data.hit_index);
               errors++;
            end
         end
      end
   end

   // directed table; typed expectations are checked on top of the predictor
   typedef struct {
      req_type w;
      bit      has_exp;
      rsp_type exp_r;
   } step_row;

   step_row steps [$];

   function automatic step_row row(req_type w, bit he, rsp_type e);
      step_row r;
      r.w = w; r.has_exp = he; r.exp_r = e;
      return r;
   endfunction

   initial begin
      rsp_type miss;
      rsp_type e;
      req_type w;
      int n_rand;
      errors = 0;
      miss = '0;
      rx_hold = 0;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      for (int s = 0; s < NUM_SPHERES; s++) tbl_valid[s] = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table: miss
      steps.push_back(row(trace_word(0, 0, 0, 16384, 0, 0), 1, miss));
      // unit sphere 10 ahead in slot 3: t = 9.0
      steps.push_back(row(load_word(3, 31'd4096, 32'sd40960, 0, 0), 0, miss));
      e = '0; e.hit = 1; e.hit_distance = 31'd36864; e.hit_index = 4'd3;
      steps.push_back(row(trace_word(0, 0, 0, 16384, 0, 0), 1, e));
      // pointing away: miss
      steps.push_back(row(trace_word(0, 0, 0, -16384, 0, 0), 1, miss));
      // inside the sphere: far root, t = 1.0
      e.hit_distance = 31'd4096;
      steps.push_back(row(trace_word(32'sd40960, 0, 0, 16384, 0, 0), 1, e));
      // identical sphere in slot 1: lower slot wins the tie
      steps.push_back(row(load_word(1, 31'd4096, 32'sd40960, 0, 0), 0, miss));
      e.hit_distance = 31'd36864; e.hit_index = 4'd1;
      steps.push_back(row(trace_word(0, 0, 0, 16384, 0, 0), 1, e));
      // negative radicand: grazing past
      steps.push_back(row(trace_word(0, 32'sd81920, 0, 16384, 0, 0), 0, miss));
      // zero radius, tangent origin
      steps.push_back(row(load_word(0, 31'd0, 0, 0, 32'sd4096), 0, miss));
      steps.push_back(row(trace_word(0, 0, 0, 0, 0, 16384), 0, miss));
      // extremes: far hit saturates, max radius, extreme coordinates
      steps.push_back(row(load_word(15, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h7FFF_FFFF), 0, miss));
      steps.push_back(row(trace_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                     16384, -16384, 16384), 0, miss));
      steps.push_back(row(trace_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                     -16384, 16384, -16384), 0, miss));
      steps.push_back(row(trace_word(0, 0, 0, 16'sh8000, 16'sh7FFF, 16'sh8000),
                          0, miss));
      steps.push_back(row(trace_word(0, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF),
                          0, miss));
      steps.push_back(row(load_word(7, 31'd8192, -32'sd20480, -32'sd4096, 32'sd12288),
                          0, miss));
      steps.push_back(row(trace_word(0, 0, 0, -11585, 0, 11585), 0, miss));

      foreach (steps[i]) begin
         idle_gap();
         send_word(steps[i].w);
         if (steps[i].has_exp && hit_queue[$] !== steps[i].exp_r) begin
            $error("directed row %0d: expected %p predicted %p",
                   i, steps[i].exp_r, hit_queue[$]);
            errors++;
         end
      end

      // long receiver hold-off while words keep coming
      rx_hold_cycles = 3000;
      rx_hold = 1;
      for (int i = 0; i < 12; i++)
         send_word(trace_word(rand_coord(), rand_coord(), rand_coord(),
                              rand_dir(), rand_dir(), rand_dir()));
      // sender pause until all results are back
      wait_drain();

      n_rand = 0;
      while (n_rand < 650) begin
         // random mix: about one word in three is a load, the rest are rays, mostly near the origin
         if ($urandom_range(0, 2) == 0) begin
            w = load_word($urandom_range(0, 15), rand_radius(),
                          rand_coord(), rand_coord(), rand_coord());
         end else begin
            w = trace_word(rand_coord(), rand_coord(), rand_coord(),
                           rand_dir(), rand_dir(), rand_dir());
         end
         if ($urandom_range(0, 9) != 0) idle_gap();
         send_word(w);
         n_rand++;
      end

      wait_drain();
      $display("run covered %0d loads and %0d traces, %0d of them hits",
               n_loads, n_traces, n_hits);
      if (errors == 0 && hit_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
